>>> hdl/rcast_pkg.sv
`default_nettype none
package rcast_pkg;

   localparam int FracBits = 16;
   localparam int MapSize  = 32;
   localparam int MapBits  = $clog2(MapSize);
   localparam int CoordW   = 10;
   localparam int DistW    = 40;
   localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};
   localparam int DivNumW  = 2 * FracBits + 1;
   localparam int DivDenW  = 48;
   localparam int DivCntW  = $clog2(DivNumW + 1);

   typedef enum logic {
      ITEM_WRITE = 1'b0,
      ITEM_CAST  = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      CSR_POS_X     = 3'd0,
      CSR_POS_Y     = 3'd1,
      CSR_DIR_X     = 3'd2,
      CSR_DIR_Y     = 3'd3,
      CSR_PLANE_X   = 3'd4,
      CSR_PLANE_Y   = 3'd5,
      CSR_VIEW_COLS = 3'd6,
      CSR_VIEW_ROWS = 3'd7
   } csr_index_type;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
      logic [2:0]  cell_value;
      logic [10:0] column;
   } item_type;

   typedef struct packed {
      logic [23:0]        pos_x;
      logic [23:0]        pos_y;
      logic signed [17:0] dir_x;
      logic signed [17:0] dir_y;
      logic signed [17:0] plane_x;
      logic signed [17:0] plane_y;
      logic [11:0]        view_cols;
      logic [10:0]        view_rows;
   } cfg_type;

   typedef struct packed {
      logic [10:0] out_column;
      logic [9:0]  draw_start;
      logic [9:0]  draw_end;
      logic [2:0]  wall_type;
      logic        hit_side;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } result_type;

   typedef struct packed {
      logic               start;
      logic [DivNumW-1:0] num;
      logic [DivDenW-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DivNumW-1:0] quot;
   } div_rsp_type;

   // Color as {red, green, blue}; y-side walls are shaded to half.
   function automatic logic [23:0] wall_color(input logic [2:0] wt, input logic side);
      logic [23:0] c;
      unique case (wt)
         3'd1:    c = 24'hFF0000;
         3'd2:    c = 24'h00FF00;
         3'd3:    c = 24'h0000FF;
         3'd4:    c = 24'hFFFFFF;
         default: c = 24'hFFFF00;
      endcase
      if (side) begin
         c = {1'b0, c[23:17], 1'b0, c[15:9], 1'b0, c[7:1]};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

>>> hdl/grid_dda_raycast_column.sv
// Grid ray caster for one wall column per cast word. A word with cmd 0 writes one cell
// of the 32 x 32 tile map and gives no result; a word with cmd 1 casts the
// ray of its column and gives one result word. A cast runs up to four divisions one
// after another on a shared divider that produces one quotient bit per cycle, and each
// grid step needs a registered map read. A two-word queue in front takes new words
// while a cast runs, and the result register holds a finished word while the next cast
// proceeds. Map cells that were never written read back as undefined values. The user
// must write configuration registers through the csr port only while no cast is in
// flight; the block itself does not enforce this.
`default_nettype none
module grid_dda_raycast_column (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [2:0]  req_cell_value,
   input  logic [10:0] req_column,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_out_column,
   output logic [9:0]  rsp_draw_start,
   output logic [9:0]  rsp_draw_end,
   output logic [2:0]  rsp_wall_type,
   output logic        rsp_hit_side,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);
   import rcast_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   div_req_type div_req;
   div_rsp_type div_rsp;
   result_type  rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_POS_X:     cfg_in.pos_x     = csr_wdata;
            CSR_POS_Y:     cfg_in.pos_y     = csr_wdata;
            CSR_DIR_X:     cfg_in.dir_x     = csr_wdata[17:0];
            CSR_DIR_Y:     cfg_in.dir_y     = csr_wdata[17:0];
            CSR_PLANE_X:   cfg_in.plane_x   = csr_wdata[17:0];
            CSR_PLANE_Y:   cfg_in.plane_y   = csr_wdata[17:0];
            CSR_VIEW_COLS: cfg_in.view_cols = csr_wdata[11:0];
            CSR_VIEW_ROWS: cfg_in.view_rows = csr_wdata[10:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_x     <= 24'd1441792;
         cfg_ff.pos_y     <= 24'd786432;
         cfg_ff.dir_x     <= -18'sd65536;
         cfg_ff.dir_y     <= 18'sd0;
         cfg_ff.plane_x   <= 18'sd0;
         cfg_ff.plane_y   <= 18'sd43254;
         cfg_ff.view_cols <= 12'd640;
         cfg_ff.view_rows <= 11'd480;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcast_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_value (req_cell_value),
      .req_column     (req_column),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   rcast_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rcast_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .cfg       (cfg_ff),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_out_column = rsp.out_column;
   assign rsp_draw_start = rsp.draw_start;
   assign rsp_draw_end   = rsp.draw_end;
   assign rsp_wall_type  = rsp.wall_type;
   assign rsp_hit_side   = rsp.hit_side;
   assign rsp_red        = rsp.red;
   assign rsp_green      = rsp.green;
   assign rsp_blue       = rsp.blue;

endmodule
`default_nettype wire

>>> hdl/rcast_front.sv
`default_nettype none
module rcast_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_cmd,
   input  logic [4:0]         req_cell_x,
   input  logic [4:0]         req_cell_y,
   input  logic [2:0]         req_cell_value,
   input  logic [10:0]        req_column,
   output logic               q_valid,
   output rcast_pkg::item_type q_item,
   input  logic               q_pop
);
   import rcast_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   item_type   item;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid & req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      item.kind       = req_cmd ? ITEM_CAST : ITEM_WRITE;
      item.cell_x     = req_cell_x;
      item.cell_y     = req_cell_y;
      item.cell_value = req_cell_value;
      item.column     = req_column;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop & q_valid);
      count_in  = count_ff + 2'(push) - 2'(q_pop & q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item;
      end
   end

endmodule
`default_nettype wire

>>> hdl/rcast_div.sv
`default_nettype none
module rcast_div (
   input  logic                   clock,
   input  logic                   reset,
   input  rcast_pkg::div_req_type req,
   output rcast_pkg::div_rsp_type rsp
);
   import rcast_pkg::*;

   logic [DivDenW-1:0] rem_ff, rem_in;
   logic [DivNumW-1:0] quo_ff, quo_in;
   logic [DivDenW-1:0] den_ff, den_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [DivDenW:0]   trial;
   logic [DivDenW:0]   diff;
   logic               fits;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DivNumW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = DivCntW'(DivNumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
         quo_in = {quo_ff[DivNumW-2:0], fits};
         cnt_in = cnt_ff - DivCntW'(1);
         if (cnt_ff == DivCntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule
`default_nettype wire

>>> hdl/rcast_engine.sv
`default_nettype none
module rcast_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  rcast_pkg::item_type    q_item,
   output logic                   q_pop,
   input  rcast_pkg::cfg_type     cfg,
   output rcast_pkg::div_req_type div_req,
   input  rcast_pkg::div_rsp_type div_rsp,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output rcast_pkg::result_type  rsp
);
   import rcast_pkg::*;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_CAM   = 15'b000000000000010,
      S_MUL   = 15'b000000000000100,
      S_RAY   = 15'b000000000001000,
      S_INVX  = 15'b000000000010000,
      S_WAITX = 15'b000000000100000,
      S_INVY  = 15'b000000001000000,
      S_WAITY = 15'b000000010000000,
      S_SIDE  = 15'b000000100000000,
      S_STEP  = 15'b000001000000000,
      S_LOOK  = 15'b000010000000000,
      S_TEST  = 15'b000100000000000,
      S_PERP  = 15'b001000000000000,
      S_HDIV  = 15'b010000000000000,
      S_OUT   = 15'b100000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [10:0]        column_ff, column_in;
   logic signed [29:0] cam_ff, cam_in;
   logic signed [47:0] prodx_ff, prodx_in, prody_ff, prody_in;
   logic signed [32:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [DistW-1:0]   dx_ff, dx_in, dy_ff, dy_in;
   logic [47:0]        sdx_ff, sdx_in, sdy_ff, sdy_in;
   logic [CoordW-1:0]  mx_ff, mx_in, my_ff, my_in;
   logic               side_ff, side_in;
   logic [2:0]         wt_ff, wt_in;
   logic [26:0]        lh_ff, lh_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;
   logic [2:0]         rd_ff;
   logic [2:0]         map_mem [MapSize*MapSize];

   logic [11:0]        sw_eff;
   logic [10:0]        h_eff;
   logic [32:0]        abs_x, abs_y;
   logic [16:0]        fx, fy;
   logic [FracBits+DistW:0] sprod_x, sprod_y;
   logic               outside;
   logic [2:0]         cell_type;
   logic [47:0]        perp;
   logic [9:0]         half_h;
   logic [25:0]        half_lh;
   logic [26:0]        end_sum;
   logic [10:0]        start_row;
   logic [26:0]        end_row;
   logic [23:0]        color;
   logic               map_we;

   assign sw_eff  = (cfg.view_cols == '0) ? 12'd1 : cfg.view_cols;
   assign h_eff   = (cfg.view_rows == '0) ? 11'd1 : cfg.view_rows;
   assign abs_x   = rx_ff[32] ? 33'(-rx_ff) : 33'(rx_ff);
   assign abs_y   = ry_ff[32] ? 33'(-ry_ff) : 33'(ry_ff);
   // Distance to the next cell border in the step direction.
   assign fx      = rx_ff[32] ? {1'b0, cfg.pos_x[FracBits-1:0]}
                              : 17'(18'h10000 - {2'b0, cfg.pos_x[FracBits-1:0]});
   assign fy      = ry_ff[32] ? {1'b0, cfg.pos_y[FracBits-1:0]}
                              : 17'(18'h10000 - {2'b0, cfg.pos_y[FracBits-1:0]});
   assign sprod_x = (FracBits+DistW+1)'(fx) * (FracBits+DistW+1)'(dx_ff);
   assign sprod_y = (FracBits+DistW+1)'(fy) * (FracBits+DistW+1)'(dy_ff);
   assign outside = (mx_ff[CoordW-1:MapBits] != '0) || (my_ff[CoordW-1:MapBits] != '0);
   assign cell_type = outside ? 3'd1 : rd_ff;
   assign perp    = side_ff ? (sdy_ff - 48'(dy_ff)) : (sdx_ff - 48'(dx_ff));
   assign half_h  = h_eff[10:1];
   assign half_lh = lh_ff[26:1];
   assign end_sum = 27'(half_lh) + 27'(half_h);
   assign start_row = (half_lh >= 26'(half_h)) ? 11'd0 : 11'(26'(half_h) - half_lh);
   assign end_row = (end_sum >= 27'(h_eff)) ? 27'(h_eff - 11'd1) : end_sum;
   assign color   = wall_color(wt_ff, side_ff);
   assign map_we  = (state_ff == S_IDLE) && q_valid && (q_item.kind == ITEM_WRITE)
                    && (q_item.cell_x < MapSize) && (q_item.cell_y < MapSize);

   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      cam_in       = cam_ff;
      prodx_in     = prodx_ff;
      prody_in     = prody_ff;
      rx_in        = rx_ff;
      ry_in        = ry_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sdx_in       = sdx_ff;
      sdy_in       = sdy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      side_in      = side_ff;
      wt_in        = wt_ff;
      lh_in        = lh_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      q_pop        = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.kind == ITEM_CAST) begin
                  column_in     = q_item.column;
                  div_req.start = 1'b1;
                  div_req.num   = DivNumW'(q_item.column) << (FracBits + 1);
                  div_req.den   = DivDenW'(sw_eff);
                  state_in      = S_CAM;
               end
            end
         end
         S_CAM: begin
            if (div_rsp.done) begin
               cam_in   = $signed({1'b0, div_rsp.quot[28:0]}) - 30'sd65536;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prodx_in = 48'(cfg.plane_x) * 48'(cam_ff);
            prody_in = 48'(cfg.plane_y) * 48'(cam_ff);
            state_in = S_RAY;
         end
         S_RAY: begin
            rx_in    = 33'(cfg.dir_x) + 33'(prodx_ff >>> FracBits);
            ry_in    = 33'(cfg.dir_y) + 33'(prody_ff >>> FracBits);
            state_in = S_INVX;
         end
         S_INVX: begin
            if (rx_ff == '0) begin
               dx_in    = DistMax;
               state_in = S_INVY;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DivNumW'(1) << (2 * FracBits);
               div_req.den   = DivDenW'(abs_x);
               state_in      = S_WAITX;
            end
         end
         S_WAITX: begin
            if (div_rsp.done) begin
               dx_in    = DistW'(div_rsp.quot);
               state_in = S_INVY;
            end
         end
         S_INVY: begin
            if (ry_ff == '0) begin
               dy_in    = DistMax;
               state_in = S_SIDE;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DivNumW'(1) << (2 * FracBits);
               div_req.den   = DivDenW'(abs_y);
               state_in      = S_WAITY;
            end
         end
         S_WAITY: begin
            if (div_rsp.done) begin
               dy_in    = DistW'(div_rsp.quot);
               state_in = S_SIDE;
            end
         end
         S_SIDE: begin
            sdx_in   = 48'(sprod_x >> FracBits);
            sdy_in   = 48'(sprod_y >> FracBits);
            mx_in    = CoordW'(cfg.pos_x[23:FracBits]);
            my_in    = CoordW'(cfg.pos_y[23:FracBits]);
            state_in = S_STEP;
         end
         S_STEP: begin
            if (sdx_ff < sdy_ff) begin
               sdx_in  = sdx_ff + 48'(dx_ff);
               mx_in   = mx_ff + (rx_ff[32] ? {CoordW{1'b1}} : CoordW'(1));
               side_in = 1'b0;
            end else begin
               sdy_in  = sdy_ff + 48'(dy_ff);
               my_in   = my_ff + (ry_ff[32] ? {CoordW{1'b1}} : CoordW'(1));
               side_in = 1'b1;
            end
            state_in = S_LOOK;
         end
         S_LOOK: begin
            // The map read for the new cell lands in rd_ff at this edge.
            state_in = S_TEST;
         end
         S_TEST: begin
            wt_in    = cell_type;
            state_in = (cell_type != 3'd0) ? S_PERP : S_STEP;
         end
         S_PERP: begin
            if (perp == '0) begin
               lh_in    = 27'(h_eff);
               state_in = S_OUT;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = DivNumW'(h_eff) << FracBits;
               div_req.den   = perp;
               state_in      = S_HDIV;
            end
         end
         S_HDIV: begin
            if (div_rsp.done) begin
               lh_in    = div_rsp.quot[26:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.out_column = column_ff;
               rsp_in.draw_start = (start_row > 11'd1023) ? 10'd1023 : start_row[9:0];
               rsp_in.draw_end   = (end_row > 27'd1023) ? 10'd1023 : end_row[9:0];
               rsp_in.wall_type  = wt_ff;
               rsp_in.hit_side   = side_ff;
               rsp_in.red        = color[23:16];
               rsp_in.green      = color[15:8];
               rsp_in.blue       = color[7:0];
               rsp_valid_in      = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff <= column_in;
      cam_ff    <= cam_in;
      prodx_ff  <= prodx_in;
      prody_ff  <= prody_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sdx_ff    <= sdx_in;
      sdy_ff    <= sdy_in;
      mx_ff     <= mx_in;
      my_ff     <= my_in;
      side_ff   <= side_in;
      wt_ff     <= wt_in;
      lh_ff     <= lh_in;
      rsp_ff    <= rsp_in;
   end

   // Tile map, indexed by x then y.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[{q_item.cell_x[MapBits-1:0], q_item.cell_y[MapBits-1:0]}] <= q_item.cell_value;
      end
      rd_ff <= map_mem[{mx_ff[MapBits-1:0], my_ff[MapBits-1:0]}];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule
`default_nettype wire

>>> hdl/rcast_checker.sv
`default_nettype none
module rcast_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_out_column,
   input logic [9:0]  rsp_draw_start,
   input logic [9:0]  rsp_draw_end,
   input logic [2:0]  rsp_wall_type,
   input logic        rsp_hit_side,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue
);

   // A stalled result word holds its column and span.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_column)
                                  && $stable(rsp_draw_start) && $stable(rsp_draw_end))
      else $error("result word changed while stalled");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_draw_start <= rsp_draw_end)
      else $error("wall span starts below its end");

   a_shade: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_side |-> !rsp_red[7] && !rsp_green[7] && !rsp_blue[7])
      else $error("y-side wall not shaded");

   a_red_wall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wall_type == 3'd1 && !rsp_hit_side
         |-> rsp_red == 8'hFF && rsp_green == 8'h00 && rsp_blue == 8'h00)
      else $error("wall type one is not red");

endmodule

bind grid_dda_raycast_column rcast_checker u_rcast_checker (.*);
`default_nettype wire
